FILE: rtl/lsei_pkg.sv
// Shared types and constants for the linear spline evaluator with integral.
// Used by the front end, the command queue, the back end and the top level.
package lsei_pkg;

    // Knot table size and its address width.
    localparam int MAX_KNOTS = 64;
    localparam int KNOT_AW   = 6;

    // Command kind codes carried in tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONINC = 2'd2;

    // One classified command between the front end and the back end.
    typedef struct packed {
        logic        kind;
        logic [5:0]  knot_index;
        logic [31:0] knot_x;
        logic [31:0] knot_y;
        logic [31:0] query_z;
    } t_cmd;

    // Back end sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD0,      // read x[0]
        S_RDN,      // read x[n-1]
        S_CHK,      // range check
        S_BRD,      // bisection read x[mid]
        S_BCMP,     // wait for the registered x[mid]
        S_RDI,      // read x[i], y[i]
        S_RDI1,     // restore the partial trapezoid product
        S_SETUP,    // form dx, dy, u
        S_MUL,      // |dy| * u
        S_DIV,      // restoring divide
        S_VAL,      // form and saturate value
        S_PMUL,     // partial trapezoid multiply
        S_PADD,     // add partial trapezoid
        S_TRD,      // trapezoid read k, k+1
        S_TWAIT,
        S_TMUL,
        S_TADD,
        S_OUT
    } t_state;

endpackage

FILE: rtl/lsei_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on lsei_pkg for the command type.
module lsei_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  logic [101:0]    i_data,
    output logic            o_cmd_valid,
    output lsei_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_ready
);
    import lsei_pkg::*;

    logic   r_full;
    t_cmd   r_cmd;

    assign o_ready     = !r_full || i_cmd_ready;
    assign o_cmd_valid = r_full;
    assign o_cmd       = r_cmd;

    // Register one classified command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd.kind       <= i_kind;
            r_cmd.knot_index <= i_data[5:0];
            r_cmd.knot_x     <= i_data[37:6];
            r_cmd.knot_y     <= i_data[69:38];
            r_cmd.query_z    <= (i_kind == KIND_QUERY) ? i_data[101:70] : 32'd0;
        end
    end

endmodule

FILE: rtl/lsei_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on lsei_pkg for the command type.
module lsei_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lsei_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output lsei_pkg::t_cmd  o_cmd
);
    import lsei_pkg::*;

    t_cmd        r_mem [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

FILE: rtl/lsei_back.sv
// Back end: knot memories, bisection, serial divide and trapezoid sum.
// Depends on lsei_pkg for the command type, states and status codes.
module lsei_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lsei_pkg::t_cmd  i_cmd,
    input  logic [6:0]      i_count,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_interp,
    output logic [63:0]     o_integral,
    output logic [1:0]      o_status
);
    import lsei_pkg::*;

    localparam int AW = KNOT_AW;

    logic [31:0] r_xmem [MAX_KNOTS];
    logic [31:0] r_ymem [MAX_KNOTS];

    t_state r_state, n_state;
    logic [AW-1:0] r_ra, r_rb, n_ra, n_rb;
    logic [31:0]   r_xa, r_ya, r_xb, r_yb;
    logic [AW:0]   r_lo, r_hi, r_n1, n_lo, n_hi, n_n1;
    logic [AW:0]   r_k, n_k;
    logic signed [31:0] r_z, n_z;
    logic [32:0]   r_dx, n_dx;
    logic [32:0]   r_u, n_u;
    logic [32:0]   r_ady, n_ady;
    logic          r_dyneg, n_dyneg;
    logic [65:0]   r_num, n_num;
    logic [65:0]   r_rem, n_rem;
    logic [65:0]   r_quo, n_quo;
    logic [6:0]    r_bit, n_bit;
    logic [63:0]   r_acc, n_acc;
    logic [65:0]   r_prod, n_prod;
    logic          r_pneg, n_pneg;
    logic [31:0]   r_val, n_val;
    logic [1:0]    r_st, n_st;
    logic          r_ov, n_ov;
    logic [65:0]   r_pprod;
    logic          r_ppneg;
    logic [AW:0]   w_mid;
    logic [AW:0]   w_cnt;
    logic [66:0]   w_rem_sh;
    logic [66:0]   w_rem_sub;
    logic signed [33:0] w_dx, w_dy, w_u, w_s, w_v, w_ps;
    logic [63:0]   w_h, w_hs;
    logic [63:0]   w_sum;
    logic          w_load;
    logic [65:0]   w_q;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign w_load = i_valid && o_ready && (i_cmd.kind == KIND_LOAD);

    // Knot count clamped to 2..MAX_KNOTS.
    always_comb begin
        if (i_count < 7'd2) w_cnt = (AW+1)'(2);
        else if ({25'd0, i_count} > 32'(MAX_KNOTS)) w_cnt = (AW+1)'(MAX_KNOTS);
        else w_cnt = (AW+1)'(i_count);
    end

    // Memory write on loads, registered reads at two addresses.
    always_ff @(posedge i_clk) begin
        if (w_load && ({26'd0, i_cmd.knot_index} < 32'(MAX_KNOTS))) begin
            r_xmem[i_cmd.knot_index[AW-1:0]] <= i_cmd.knot_x;
            r_ymem[i_cmd.knot_index[AW-1:0]] <= i_cmd.knot_y;
        end
        r_xa <= r_xmem[r_ra];
        r_ya <= r_ymem[r_ra];
        r_xb <= r_xmem[r_rb];
        r_yb <= r_ymem[r_rb];
    end

    assign w_mid     = (r_lo + r_hi) >> 1;
    assign w_rem_sh  = {r_rem, r_num[65]};
    assign w_rem_sub = w_rem_sh - {34'd0, r_dx};
    assign w_dx = 34'(signed'(r_xb)) - 34'(signed'(r_xa));
    assign w_dy = 34'(signed'(r_yb)) - 34'(signed'(r_ya));
    assign w_u  = 34'(r_z) - 34'(signed'(r_xa));
    assign w_q  = r_quo;
    assign w_v  = r_dyneg ? 34'(signed'(r_ya)) - 34'(w_q[32:0])
                          : 34'(signed'(r_ya)) + 34'(w_q[32:0]);
    assign w_ps = 34'(signed'(r_ya)) + 34'(signed'(r_val));
    assign w_h  = 64'((r_prod + 66'd1) >> 1);
    assign w_hs = r_pneg ? (64'd0 - w_h) : w_h;
    assign w_sum = r_acc + w_hs;
    always_comb begin
        w_s = 34'(signed'(r_ya)) + 34'(signed'(r_yb));
    end

    // Sequencer.
    always_comb begin
        n_state = r_state; n_ra = r_ra; n_rb = r_rb; n_lo = r_lo; n_hi = r_hi;
        n_n1 = r_n1; n_k = r_k; n_z = r_z; n_dx = r_dx; n_u = r_u;
        n_ady = r_ady; n_dyneg = r_dyneg; n_num = r_num; n_rem = r_rem;
        n_quo = r_quo; n_bit = r_bit; n_acc = r_acc; n_prod = r_prod;
        n_pneg = r_pneg; n_val = r_val; n_st = r_st; n_ov = r_ov;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_ov && i_cmd.kind == KIND_QUERY) begin
                    n_z = signed'(i_cmd.query_z);
                    n_n1 = w_cnt - (AW+1)'(1);
                    n_ra = '0;
                    n_rb = AW'(w_cnt - (AW+1)'(1));
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_CHK;
            S_CHK: begin
                if (r_z < signed'(r_xa) || r_z > signed'(r_xb)) begin
                    n_st = ST_RANGE; n_val = '0; n_acc = '0; n_state = S_OUT;
                end else begin
                    n_lo = '0; n_hi = r_n1; n_state = S_BRD;
                end
            end
            S_RDN: n_state = S_CHK;
            S_BRD: begin
                if (r_hi - r_lo > (AW+1)'(1)) begin
                    n_ra = AW'(w_mid); n_state = S_BCMP;
                end else begin
                    n_ra = AW'(r_lo); n_rb = AW'(r_lo + (AW+1)'(1));
                    n_state = S_RDI;
                end
            end
            S_BCMP: n_state = S_TWAIT;
            S_TWAIT: begin
                // Bisection compare on the registered x[mid].
                if (r_z > signed'(r_xa)) n_lo = (AW+1)'(r_ra);
                else n_hi = (AW+1)'(r_ra);
                n_state = S_BRD;
            end
            S_RDI: n_state = S_SETUP;
            S_SETUP: begin
                if (w_dx <= 0) begin
                    n_st = ST_NONINC; n_val = '0; n_acc = '0; n_state = S_OUT;
                end else begin
                    n_dx = 33'(w_dx); n_u = 33'(w_u);
                    n_dyneg = w_dy < 0;
                    n_ady = 33'(w_dy < 0 ? -w_dy : w_dy);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_num = 66'(r_ady) * 66'(r_u) + 66'(r_dx >> 1);
                n_rem = '0; n_quo = '0; n_bit = 7'd66;
                n_state = S_DIV;
            end
            S_DIV: begin
                // One quotient bit a cycle.
                n_num = r_num << 1;
                if (!w_rem_sub[66]) begin
                    n_rem = w_rem_sub[65:0]; n_quo = {r_quo[64:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[65:0]; n_quo = {r_quo[64:0], 1'b0};
                end
                n_bit = r_bit - 7'd1;
                if (r_bit == 7'd1) n_state = S_VAL;
            end
            S_VAL: begin
                if (w_q[65:33] != '0)
                    n_val = r_dyneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else if (w_v > 34'sd2147483647) n_val = 32'h7FFF_FFFF;
                else if (w_v < -34'sd2147483648) n_val = 32'h8000_0000;
                else n_val = 32'(w_v);
                n_state = S_PMUL;
            end
            S_PMUL: begin
                // Partial trapezoid from x[i] to z, right ordinate is the value; u >= 0.
                n_prod = 66'(r_u) * 66'(w_ps[33] ? 33'(-w_ps) : 33'(w_ps));
                n_pneg = w_ps[33];
                n_acc = '0; n_k = '0;
                n_ra = '0; n_rb = AW'(1);
                n_state = (r_ra == '0) ? S_PADD : S_TRD;
                n_lo = (AW+1)'(r_ra);
                n_st = ST_OK;
            end
            S_TRD: begin
                n_state = S_TMUL;
            end
            S_TMUL: begin
                n_prod = 66'(w_dx[33] ? 33'(-w_dx) : 33'(w_dx))
                       * 66'(w_s[33] ? 33'(-w_s) : 33'(w_s));
                n_pneg = w_dx[33] != w_s[33];
                n_state = S_TADD;
            end
            S_TADD: begin
                n_acc = (r_acc[63] == w_hs[63] && w_sum[63] != r_acc[63])
                      ? (r_acc[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                      : w_sum;
                n_k = r_k + (AW+1)'(1);
                n_ra = AW'(r_k + (AW+1)'(1));
                n_rb = AW'(r_k + (AW+1)'(2));
                if (r_k + (AW+1)'(1) == r_lo) begin
                    n_state = S_RDI1;
                    n_ra = AW'(r_lo);
                end else n_state = S_TRD;
            end
            S_RDI1: begin
                // Bring back the partial trapezoid product for the final add.
                n_prod = r_pprod;
                n_pneg = r_ppneg;
                n_state = S_PADD;
            end
            S_PADD: begin
                n_acc = (r_acc[63] == w_hs[63] && w_sum[63] != r_acc[63])
                      ? (r_acc[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                      : w_sum;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The partial trapezoid product is computed once in S_PMUL and kept
    // aside while whole trapezoids reuse the multiplier.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PMUL) begin
            r_pprod <= n_prod;
            r_ppneg <= n_pneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_ra <= n_ra; r_rb <= n_rb; r_lo <= n_lo; r_hi <= n_hi; r_n1 <= n_n1;
        r_k <= n_k; r_z <= n_z; r_dx <= n_dx; r_u <= n_u;
        r_ady <= n_ady; r_dyneg <= n_dyneg; r_num <= n_num; r_rem <= n_rem;
        r_quo <= n_quo; r_bit <= n_bit; r_acc <= n_acc;
        r_pneg <= n_pneg; r_val <= n_val; r_st <= n_st;
        r_prod <= n_prod;
    end

    assign o_valid    = r_ov;
    assign o_interp   = r_val;
    assign o_integral = r_acc;
    assign o_status   = r_st;

endmodule

FILE: rtl/linear_spline_eval_integral.sv
// Piecewise linear interpolation with integral over a loaded knot table.
// A query passes a range check, a bisection of up to 6 steps, a serial restoring divide,
// the value with saturation and a sum of up to 62 whole trapezoids plus the partial one; an
// out-of-range or non-increasing query skips to the result. A load writes one knot to the table.
// New commands enter the back end only when idle with no result waiting; loads go back to back.
// Reset (i_rst_n low, synchronous) clears control state and sets knot_count to 2; knots stay unset.
module linear_spline_eval_integral (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // knot_index[5:0], knot_x[37:6], knot_y[69:38], query_z[101:70], zero pad
    input  logic [103:0] s_axis_tdata,
    // kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // interp_value[31:0], integral_value[95:32], status[97:96], zero pad
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata
);
    import lsei_pkg::*;

    logic [6:0]  r_count;
    logic        w_fv, w_fr, w_qv, w_qr;
    t_cmd        w_fcmd, w_qcmd;
    logic [31:0] w_interp;
    logic [63:0] w_integral;
    logic [1:0]  w_status;

    // Knot count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 7'd2;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    lsei_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_data(s_axis_tdata[101:0]),
        .o_cmd_valid(w_fv), .o_cmd(w_fcmd), .i_cmd_ready(w_fr)
    );

    lsei_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_cmd(w_fcmd),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_qcmd)
    );

    lsei_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_qcmd), .i_count(r_count),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_interp(w_interp), .o_integral(w_integral), .o_status(w_status)
    );

    assign m_axis_tdata = {6'd0, w_status, w_integral, w_interp};

endmodule

FILE: dv/tb.sv
// Self-checking testbench for linear_spline_eval_integral: knot loads, queries, stalls.
// Depends on lsei_pkg for the kind and status codes and on the top level RTL.
module tb;
    import lsei_pkg::*;

    // Expected outcome of one query.
    typedef struct {
        logic [31:0] value;
        logic [63:0] area;
        logic [1:0]  status;
    } t_query_result;

    // Keeps a copy of the knot table and the queue of pending query results.
    class spline_scoreboard;
        longint        kx[64];
        longint        ky[64];
        int            knot_count = 2;
        t_query_result pending_results[$];
        int            errors = 0;
        int            n_loads = 0;
        int            n_queries = 0;
        int            n_status[3] = '{0, 0, 0};

        task report(string what);
            errors++;
            $display("ERROR at %0t: %s", $realtime, what);
        endtask

        function bit [63:0] trapezoid(longint d, longint s);
            bit [63:0] ad;
            bit [63:0] as_mag;
            bit [63:0] h;
            ad = (d < 0) ? -d : d;
            as_mag = (s < 0) ? -s : s;
            h = (ad * as_mag + 64'd1) >> 1;
            return ((d < 0) != (s < 0)) ? (64'd0 - h) : h;
        endfunction

        function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
            bit [63:0] r;
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63])
                return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return r;
        endfunction

        function int used_knots();
            return (knot_count < 2) ? 2 : (knot_count > 64) ? 64 : knot_count;
        endfunction

        // Note one accepted input transfer and predict its result, if any.
        function void note_input(logic kind, logic [5:0] idx, logic [31:0] x,
                                 logic [31:0] y, logic [31:0] zbits);
            int            n;
            int            lo;
            int            hi;
            int            mid;
            longint        z;
            longint        dx;
            longint        dy;
            longint        u;
            longint        val;
            bit [63:0]     ady;
            bit [63:0]     uu;
            bit [63:0]     q;
            bit [63:0]     acc;
            t_query_result r;
            if (kind == KIND_LOAD) begin
                kx[idx] = longint'($signed(x));
                ky[idx] = longint'($signed(y));
                n_loads++;
                return;
            end
            n_queries++;
            n = used_knots();
            z = longint'($signed(zbits));
            r.value = '0;
            r.area = '0;
            if (z < kx[0] || z > kx[n-1]) begin
                r.status = ST_RANGE;
            end else begin
                // Bisection for the interval that holds z.
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (z > kx[mid]) lo = mid;
                    else hi = mid;
                end
                dx = kx[lo+1] - kx[lo];
                if (dx <= 0) begin
                    r.status = ST_NONINC;
                end else begin
                    u = z - kx[lo];
                    dy = ky[lo+1] - ky[lo];
                    ady = (dy < 0) ? -dy : dy;
                    uu = u;
                    q = (ady * uu + (64'(dx) >> 1)) / 64'(dx);
                    val = (dy < 0) ? ky[lo] - longint'(q) : ky[lo] + longint'(q);
                    if (val > 64'sd2147483647) val = 64'sd2147483647;
                    if (val < -64'sd2147483648) val = -64'sd2147483648;
                    // Whole trapezoids first, then the partial one up to z.
                    acc = '0;
                    for (int k = 0; k < lo; k++)
                        acc = sat_add(acc, trapezoid(kx[k+1] - kx[k], ky[k] + ky[k+1]));
                    acc = sat_add(acc, trapezoid(u, ky[lo] + val));
                    r.value = val[31:0];
                    r.area = acc;
                    r.status = ST_OK;
                end
            end
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest prediction.
        task check_result(logic [103:0] data);
            t_query_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            e = pending_results.pop_front();
            if (data[97:96] <= 2) n_status[data[97:96]]++;
            if (data[97:96] !== e.status)
                report($sformatf("status %0d, want %0d", data[97:96], e.status));
            if (data[31:0] !== e.value)
                report($sformatf("value %h, want %h", data[31:0], e.value));
            if (data[95:32] !== e.area)
                report($sformatf("integral %h, want %h", data[95:32], e.area));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // knot_index, knot_x, knot_y, query_z, zero pad
    logic [103:0] s_axis_tdata = '0;
    // kind
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // interp_value, integral_value, status, zero pad
    logic [103:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [6:0]   i_cfg_wdata = '0;

    spline_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 4;
    bit hold_request = 1'b0;

    linear_spline_eval_integral u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: checks each result and stalls in one of four random patterns, plus a long hold-off on request.
    always @(posedge i_clk) begin : result_sink
        static int cyc = 0;
        static int hold_left = 0;
        static int mode = 0;
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        cyc++;
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((cyc % 8) < 5);
            endcase
        end
    end

    // Offer one item and wait for its transfer; bursts mostly end with a random gap.
    task send_item(logic kind, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                   logic [31:0] z);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, z, y, x, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(kind, idx, x, y, z);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 6))
                    @(posedge i_clk);
            end
        end
    endtask

    task load_knot(int idx, longint x, longint y);
        send_item(KIND_LOAD, idx[5:0], x[31:0], y[31:0], $urandom);
    endtask

    task query_at(longint z);
        send_item(KIND_QUERY, 6'($urandom), $urandom, $urandom, z[31:0]);
    endtask

    // Wait until every predicted result has arrived, then let the block drain.
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task write_count(int value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[6:0];
        @(posedge i_clk);
        sb.knot_count = value & 8'h7F;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load all 64 knots; mode 0 small steps, 1 full scale, 2 small with a repeated x.
    task load_table(int mode);
        longint x;
        longint y;
        int dup;
        dup = $urandom_range(1, 63);
        x = (mode == 1) ? -64'sd2147483648 + $urandom_range(0, 1 << 20)
                        : -longint'($urandom_range(0, 1 << 22));
        for (int k = 0; k < 64; k++) begin
            y = (mode == 1) ? longint'(int'($urandom))
                            : longint'(int'($urandom_range(0, 1 << 21))) - (1 << 20);
            load_knot(k, x, y);
            if (mode == 1) x += (64'sd1 << 26) - $urandom_range(0, 1 << 20);
            else if (!(mode == 2 && k + 1 == dup)) x += $urandom_range(1, 1 << 18);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
        end
    endtask

    // A query mostly inside the used span, sometimes on a knot, just below the first knot or anywhere.
    task random_query();
        int n;
        int k;
        longint a;
        longint b;
        bit [63:0] span;
        bit [63:0] pick;
        n = sb.used_knots();
        k = $urandom_range(0, n - 2);
        a = sb.kx[k];
        b = sb.kx[k+1];
        case ($urandom_range(0, 9))
            0: query_at(longint'(int'($urandom)));
            1: query_at(b);
            2: query_at(a);
            3: query_at(sb.kx[0] - $urandom_range(1, 1000));
            default: begin
                if (b > a) begin
                    span = b - a + 1;
                    pick = {$urandom, $urandom};
                    query_at(a + longint'(pick % span));
                end else begin
                    query_at(a);
                end
            end
        endcase
    endtask

    initial begin : stimulus
        int counts[7] = '{64, 2, 0, 127, 65, 1, 5};
        int phase;
        int mode;
        int cnt;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two-knot table, range edges, repeated abscissa, saturation.
        write_count(2);
        load_knot(0, -64'sd65536, 64'sd131072);
        load_knot(1, 64'sd196608, -64'sd327680);
        load_knot(63, 64'sd2147483647, -64'sd2147483648);
        query_at(-64'sd65536);
        query_at(64'sd196608);
        query_at(64'sd65536);
        query_at(-64'sd65537);
        query_at(64'sd196609);
        query_at(-64'sd2147483648);
        query_at(64'sd2147483647);
        load_knot(1, -64'sd65536, 64'sd0);
        query_at(-64'sd65536);
        load_knot(1, -64'sd65537, 64'sd0);
        query_at(-64'sd65536);
        load_knot(0, -64'sd2147483648, 64'sd2147483647);
        load_knot(1, 64'sd2147483647, 64'sd2147483647);
        query_at(64'sd2147483647);
        query_at(64'sd0);
        load_knot(1, 64'sd2147483647, -64'sd2147483648);
        query_at(64'sd1000);
        query_at(64'sd2147483647);
        drain();

        // Random phases: new count, new table, then mostly well-formed queries and occasional knot loads.
        phase = 0;
        while (items_sent < 1050) begin
            drain();
            cnt = (phase < 7) ? counts[phase]
                  : ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(2, 16);
            write_count(cnt);
            mode = (phase % 3 == 1) ? 1 : ($urandom_range(0, 4) == 0) ? 2 : 0;
            load_table(mode);
            if (phase == 2) hold_request = 1'b1;
            repeat ($urandom_range(30, 60)) begin
                if ($urandom_range(0, 19) == 0)
                    load_knot($urandom_range(0, 63), longint'(int'($urandom)),
                              longint'(int'($urandom)));
                else
                    random_query();
            end
            phase++;
        end
        drain();

        $display("Covered %0d loads and %0d queries over %0d table phases.",
                 sb.n_loads, sb.n_queries, phase);
        $display("Status counts: ok %0d, out of range %0d, non-increasing %0d.",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2]);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("linear_spline_eval_integral: match");
        end else begin
            $display("linear_spline_eval_integral: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #20000000;
        $display("linear_spline_eval_integral: mismatch");
        $finish;
    end

endmodule
